// File: src/particle_step_with_atlas_frame_top_macros.svh
// Assertion macros shared by the particle step RTL.
`ifndef PARTICLE_STEP_WITH_ATLAS_FRAME_TOP_MACROS_SVH
`define PARTICLE_STEP_WITH_ATLAS_FRAME_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication; cons may open with a fixed delay.
`define PSAF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
    else $error("psaf assertion failed");
// Next-cycle implication.
`define PSAF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> cons) \
    else $error("psaf assertion failed");
`else
`define PSAF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PSAF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: src/psaf_pkg.sv
// Shared types and constants for the particle step block.
package psaf_pkg;

  localparam int DATA_W     = 32;
  localparam int UV_W       = 16;
  localparam int ATLAS_REG_W = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic signed [DATA_W-1:0] GRAVITY_RST = -32'sd642908;
  localparam logic [ATLAS_REG_W-1:0]   ATLAS_SIDE_RST = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_COLS    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0]        new_age;
    logic [DATA_W-1:0]        life;
    logic                     alive;
    logic                     clamp;
    logic                     life_zero;
  } motion_t;

endpackage

// File: src/psaf_udiv.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module psaf_udiv #(
  parameter int N_W    = 8,
  parameter int D_W    = 8,
  parameter int Q_W    = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [N_W-1:0]    num_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [D_W-1:0]    rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_r  [N_W];
  logic [D_W-1:0]    rem_r  [N_W];
  logic [Q_W-1:0]    quo_r  [N_W];
  logic [N_W-1:0]    num_r  [N_W];
  logic [D_W-1:0]    den_r  [N_W];
  logic [SIDE_W-1:0] side_r [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_step
    logic              vld_in;
    logic [D_W-1:0]    rem_in;
    logic [D_W-1:0]    den_in;
    logic [Q_W-1:0]    quo_in;
    logic [N_W-1:0]    num_in;
    logic [SIDE_W-1:0] sb_in;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;
    logic [Q_W:0]      quo_ext;
    logic [N_W:0]      num_ext;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign sb_in  = side_i;
    end else begin : g_chain
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
      assign sb_in  = side_r[s-1];
    end

    // bring down the next dividend bit and try a subtract
    assign trial   = {rem_in, num_in[N_W-1]};
    assign diff    = trial - {1'b0, den_in};
    assign ge      = trial >= {1'b0, den_in};
    assign quo_ext = {quo_in, ge};
    assign num_ext = {num_in, 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_r[s]  <= quo_ext[Q_W-1:0];
      num_r[s]  <= num_ext[N_W-1:0];
      den_r[s]  <= den_in;
      side_r[s] <= sb_in;
    end
  end

  assign valid_o = vld_r[N_W-1];
  assign quo_o   = quo_r[N_W-1];
  assign rem_o   = rem_r[N_W-1];
  assign side_o  = side_r[N_W-1];

endmodule

// File: src/psaf_front.sv
// Five-stage motion and age pipeline producing the atlas progression product.
module psaf_front #(
  parameter int FRAC_BITS = 16,
  parameter int CNT_W     = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  input  logic signed [31:0]           in_pos_x,
  input  logic signed [31:0]           in_pos_y,
  input  logic signed [31:0]           in_pos_z,
  input  logic signed [31:0]           in_vel_x,
  input  logic signed [31:0]           in_vel_y,
  input  logic signed [31:0]           in_vel_z,
  input  logic [31:0]                  in_age,
  input  logic [31:0]                  in_life_length,
  input  logic signed [31:0]           in_gravity_weight,
  input  logic [31:0]                  in_time_step,
  input  logic                         in_looping,
  input  logic                         in_first_frame,
  input  logic signed [31:0]           gravity_accel,
  input  logic [CNT_W-1:0]             count,
  output logic                         valid_o,
  output psaf_pkg::motion_t            mot_o,
  output logic [32+CNT_W-1:0]          prod_o
);

  localparam int PROD_W = 32 + CNT_W;

  logic [31:0] dt;
  assign dt = in_first_frame ? 32'd0 : in_time_step;

  // stage 1: gravity product, x/z displacement, raw age sum
  logic               v1_r;
  logic signed [31:0] px1_r, py1_r, pz1_r, vy1_r;
  logic [31:0]        dt1_r, life1_r;
  logic               loop1_r;
  logic signed [63:0] gwp1_r;
  logic signed [64:0] pxp1_r, pzp1_r;
  logic [32:0]        sum1_r;

  // stage 2
  logic               v2_r;
  logic signed [31:0] px2_r, py2_r, pz2_r, vy2_r;
  logic [31:0]        dt2_r, life2_r, na2_r;
  logic               loop2_r;
  logic signed [64:0] gdt2_r;
  logic signed [31:0] gw1;

  // stage 3
  logic               v3_r;
  logic signed [31:0] px3_r, py3_r, pz3_r, vy3_r;
  logic [31:0]        dt3_r, life3_r, na3_r;
  logic               alive3_r, clamp3_r;
  logic [31:0]        na_wrap;

  // stage 4
  logic               v4_r;
  logic signed [31:0] px4_r, py4_r, pz4_r, vy4_r;
  logic [31:0]        na4_r, life4_r;
  logic               alive4_r, clamp4_r;
  logic signed [64:0] vydt4_r;
  logic [PROD_W-1:0]  prod4_r;

  // stage 5
  logic               v5_r;
  psaf_pkg::motion_t  mot5_r;
  logic [PROD_W-1:0]  prod5_r;

  assign gw1 = gwp1_r[FRAC_BITS+31:FRAC_BITS];

  always_comb begin
    na_wrap = na2_r;
    if (loop2_r && (na2_r > life2_r)) begin
      na_wrap = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    px1_r   <= in_pos_x;
    py1_r   <= in_pos_y;
    pz1_r   <= in_pos_z;
    vy1_r   <= in_vel_y;
    dt1_r   <= dt;
    life1_r <= in_life_length;
    loop1_r <= in_looping;
    gwp1_r  <= gravity_accel * in_gravity_weight;
    pxp1_r  <= in_vel_x * $signed({1'b0, dt});
    pzp1_r  <= in_vel_z * $signed({1'b0, dt});
    sum1_r  <= {1'b0, in_age} + {1'b0, dt};

    px2_r   <= px1_r + pxp1_r[FRAC_BITS+31:FRAC_BITS];
    pz2_r   <= pz1_r + pzp1_r[FRAC_BITS+31:FRAC_BITS];
    py2_r   <= py1_r;
    vy2_r   <= vy1_r;
    dt2_r   <= dt1_r;
    life2_r <= life1_r;
    loop2_r <= loop1_r;
    gdt2_r  <= gw1 * $signed({1'b0, dt1_r});
    // saturate the age at all ones
    na2_r   <= sum1_r[32] ? '1 : sum1_r[31:0];

    px3_r    <= px2_r;
    pz3_r    <= pz2_r;
    py3_r    <= py2_r;
    vy3_r    <= vy2_r + gdt2_r[FRAC_BITS+31:FRAC_BITS];
    dt3_r    <= dt2_r;
    life3_r  <= life2_r;
    na3_r    <= na_wrap;
    alive3_r <= loop2_r || (life2_r > na2_r);
    clamp3_r <= na_wrap >= life2_r;

    px4_r    <= px3_r;
    pz4_r    <= pz3_r;
    py4_r    <= py3_r;
    vy4_r    <= vy3_r;
    na4_r    <= na3_r;
    life4_r  <= life3_r;
    alive4_r <= alive3_r;
    clamp4_r <= clamp3_r;
    vydt4_r  <= vy3_r * $signed({1'b0, dt3_r});
    prod4_r  <= PROD_W'(na3_r) * PROD_W'(count);

    mot5_r.pos_x     <= px4_r;
    mot5_r.pos_y     <= py4_r + vydt4_r[FRAC_BITS+31:FRAC_BITS];
    mot5_r.pos_z     <= pz4_r;
    mot5_r.vel_y     <= vy4_r;
    mot5_r.new_age   <= na4_r;
    mot5_r.life      <= life4_r;
    mot5_r.alive     <= alive4_r;
    mot5_r.clamp     <= clamp4_r;
    mot5_r.life_zero <= life4_r == 32'd0;
    prod5_r          <= prod4_r;
  end

  assign valid_o = v5_r;
  assign mot_o   = mot5_r;
  assign prod_o  = prod5_r;

endmodule

// File: src/particle_step_with_atlas_frame_top.sv
// CNT_W = clog2(MAX_ATLAS_SIDE^2 + 1) and SIDE_W = clog2(MAX_ATLAS_SIDE + 1);
//   the front end feeds the progression, cell and offset dividers in turn.
// Throughput: one per cycle while not busy; bit-per-stage dividers set the depth.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) flushes the pipeline, loads register defaults and
//   holds busy high until the cycle after reset is released.
`include "particle_step_with_atlas_frame_top_macros.svh"
module particle_step_with_atlas_frame_top #(
  parameter int FRAC_BITS      = 16,
  parameter int MAX_ATLAS_SIDE = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_vel_x,
  input  logic signed [31:0]  in_vel_y,
  input  logic signed [31:0]  in_vel_z,
  input  logic [31:0]         in_age,
  input  logic [31:0]         in_life_length,
  input  logic signed [31:0]  in_gravity_weight,
  input  logic [31:0]         in_time_step,
  input  logic                in_looping,
  input  logic                in_first_frame,
  output logic                out_valid,
  output logic signed [31:0]  out_new_pos_x,
  output logic signed [31:0]  out_new_pos_y,
  output logic signed [31:0]  out_new_pos_z,
  output logic signed [31:0]  out_new_vel_y,
  output logic [31:0]         out_new_age,
  output logic                out_alive,
  output logic [15:0]         out_cur_u,
  output logic [15:0]         out_cur_v,
  output logic [15:0]         out_next_u,
  output logic [15:0]         out_next_v,
  output logic [15:0]         out_blend,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int UV_W    = psaf_pkg::UV_W;
  localparam int SIDE_W  = $clog2(MAX_ATLAS_SIDE + 1);
  localparam int CNT_W   = $clog2(MAX_ATLAS_SIDE * MAX_ATLAS_SIDE + 1);
  localparam int PROD_W  = 32 + CNT_W;
  localparam int MAIN_N  = PROD_W + UV_W;
  localparam int MAIN_Q  = UV_W + CNT_W;
  localparam int UVN_W   = SIDE_W + UV_W;
  localparam int MOT_W   = $bits(psaf_pkg::motion_t);
  localparam int CELL_SW = MOT_W + UV_W + CNT_W;
  localparam int UV_SW   = MOT_W + UV_W;
  localparam int LATENCY = 5 + MAIN_N + CNT_W + 1 + UVN_W;

  // configuration registers
  logic signed [31:0]                grav_r;
  logic [psaf_pkg::ATLAS_REG_W-1:0] rows_r, cols_r;
  logic                              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= psaf_pkg::GRAVITY_RST;
      rows_r <= psaf_pkg::ATLAS_SIDE_RST;
      cols_r <= psaf_pkg::ATLAS_SIDE_RST;
    end else if (cfg_wr_en) begin
      unique case (psaf_pkg::cfg_reg_t'(cfg_index))
        psaf_pkg::CFG_GRAVITY: grav_r <= cfg_wdata;
        psaf_pkg::CFG_ROWS:    rows_r <= cfg_wdata[psaf_pkg::ATLAS_REG_W-1:0];
        psaf_pkg::CFG_COLS:    cols_r <= cfg_wdata[psaf_pkg::ATLAS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // clamp the atlas sides into 1..MAX_ATLAS_SIDE
  logic [SIDE_W-1:0] rows_c, cols_c;
  logic [CNT_W-1:0]  count, last_idx;

  always_comb begin
    if (rows_r == '0) begin
      rows_c = SIDE_W'(1);
    end else if (32'(rows_r) > MAX_ATLAS_SIDE) begin
      rows_c = SIDE_W'(MAX_ATLAS_SIDE);
    end else begin
      rows_c = SIDE_W'(rows_r);
    end
    if (cols_r == '0) begin
      cols_c = SIDE_W'(1);
    end else if (32'(cols_r) > MAX_ATLAS_SIDE) begin
      cols_c = SIDE_W'(MAX_ATLAS_SIDE);
    end else begin
      cols_c = SIDE_W'(cols_r);
    end
  end

  assign count    = CNT_W'(rows_c) * CNT_W'(cols_c);
  assign last_idx = count - CNT_W'(1);

  logic in_accept;
  assign in_accept = start && !busy_r;

  // motion front end
  logic              f_valid;
  psaf_pkg::motion_t f_mot;
  logic [PROD_W-1:0] f_prod;

  psaf_front #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .valid_i           (in_accept),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_vel_x          (in_vel_x),
    .in_vel_y          (in_vel_y),
    .in_vel_z          (in_vel_z),
    .in_age            (in_age),
    .in_life_length    (in_life_length),
    .in_gravity_weight (in_gravity_weight),
    .in_time_step      (in_time_step),
    .in_looping        (in_looping),
    .in_first_frame    (in_first_frame),
    .gravity_accel     (grav_r),
    .count             (count),
    .valid_o           (f_valid),
    .mot_o             (f_mot),
    .prod_o            (f_prod)
  );

  // progression divide: quotient holds the cell index above the blend fraction
  logic              md_valid;
  logic [MAIN_Q-1:0] md_quo;
  logic [MOT_W-1:0]  md_side;
  psaf_pkg::motion_t md_mot;

  psaf_udiv #(
    .N_W    (MAIN_N),
    .D_W    (32),
    .Q_W    (MAIN_Q),
    .SIDE_W (MOT_W)
  ) u_main_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (f_valid),
    .num_i   ({f_prod, UV_W'(0)}),
    .den_i   (f_mot.life),
    .side_i  (f_mot),
    .valid_o (md_valid),
    .quo_o   (md_quo),
    .rem_o   (),
    .side_o  (md_side)
  );

  assign md_mot = psaf_pkg::motion_t'(md_side);

  logic [UV_W-1:0]  md_blend;
  logic [CNT_W-1:0] md_cur;

  always_comb begin
    md_blend = md_mot.life_zero ? '0 : md_quo[UV_W-1:0];
    // past the end or zero lifetime: pin to the last cell
    md_cur   = (md_mot.clamp || md_mot.life_zero) ? last_idx : md_quo[UV_W +: CNT_W];
  end

  // split the cell index into row and column
  logic               cd_valid;
  logic [CNT_W-1:0]   cd_quo;
  logic [SIDE_W-1:0]  cd_rem;
  logic [CELL_SW-1:0] cd_side;

  psaf_udiv #(
    .N_W    (CNT_W),
    .D_W    (SIDE_W),
    .Q_W    (CNT_W),
    .SIDE_W (CELL_SW)
  ) u_cell_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (md_valid),
    .num_i   (md_cur),
    .den_i   (cols_c),
    .side_i  ({md_side, md_blend, md_cur}),
    .valid_o (cd_valid),
    .quo_o   (cd_quo),
    .rem_o   (cd_rem),
    .side_o  (cd_side)
  );

  logic [MOT_W-1:0]  cd_mot;
  logic [UV_W-1:0]   cd_blend;
  logic [CNT_W-1:0]  cd_cur;
  logic [SIDE_W-1:0] cd_row;
  logic [SIDE_W:0]   col_inc;
  logic              cd_last;
  logic [SIDE_W-1:0] ncol_nxt, nrow_nxt;

  assign cd_mot   = cd_side[CELL_SW-1 -: MOT_W];
  assign cd_blend = cd_side[CNT_W +: UV_W];
  assign cd_cur   = cd_side[CNT_W-1:0];
  assign cd_row   = cd_quo[SIDE_W-1:0];
  assign cd_last  = cd_cur == last_idx;
  assign col_inc  = {1'b0, cd_rem} + (SIDE_W+1)'(1);

  always_comb begin
    ncol_nxt = cd_rem;
    nrow_nxt = cd_row;
    if (!cd_last) begin
      if (col_inc == {1'b0, cols_c}) begin
        ncol_nxt = '0;
        nrow_nxt = cd_row + SIDE_W'(1);
      end else begin
        ncol_nxt = col_inc[SIDE_W-1:0];
      end
    end
  end

  logic              nx_valid_r;
  logic [MOT_W-1:0]  nx_mot_r;
  logic [UV_W-1:0]   nx_blend_r;
  logic [SIDE_W-1:0] col_r, row_r, ncol_r, nrow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_valid_r <= 1'b0;
    end else begin
      nx_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    nx_mot_r   <= cd_mot;
    nx_blend_r <= cd_blend;
    col_r      <= cd_rem;
    row_r      <= cd_row;
    ncol_r     <= ncol_nxt;
    nrow_r     <= nrow_nxt;
  end

  // offsets: index over side, as Q0.16
  logic             cu_valid;
  logic [UV_W-1:0]  cu_q, cv_q, nu_q, nv_q;
  logic [UV_SW-1:0] cu_side;

  psaf_udiv #(
    .N_W (UVN_W), .D_W (SIDE_W), .Q_W (UV_W), .SIDE_W (UV_SW)
  ) u_cu_div (
    .clk (clk), .rst_n (rst_n), .valid_i (nx_valid_r),
    .num_i ({col_r, UV_W'(0)}), .den_i (cols_c), .side_i ({nx_mot_r, nx_blend_r}),
    .valid_o (cu_valid), .quo_o (cu_q), .rem_o (), .side_o (cu_side)
  );

  psaf_udiv #(
    .N_W (UVN_W), .D_W (SIDE_W), .Q_W (UV_W), .SIDE_W (1)
  ) u_cv_div (
    .clk (clk), .rst_n (rst_n), .valid_i (nx_valid_r),
    .num_i ({row_r, UV_W'(0)}), .den_i (rows_c), .side_i (1'b0),
    .valid_o (), .quo_o (cv_q), .rem_o (), .side_o ()
  );

  psaf_udiv #(
    .N_W (UVN_W), .D_W (SIDE_W), .Q_W (UV_W), .SIDE_W (1)
  ) u_nu_div (
    .clk (clk), .rst_n (rst_n), .valid_i (nx_valid_r),
    .num_i ({ncol_r, UV_W'(0)}), .den_i (cols_c), .side_i (1'b0),
    .valid_o (), .quo_o (nu_q), .rem_o (), .side_o ()
  );

  psaf_udiv #(
    .N_W (UVN_W), .D_W (SIDE_W), .Q_W (UV_W), .SIDE_W (1)
  ) u_nv_div (
    .clk (clk), .rst_n (rst_n), .valid_i (nx_valid_r),
    .num_i ({nrow_r, UV_W'(0)}), .den_i (rows_c), .side_i (1'b0),
    .valid_o (), .quo_o (nv_q), .rem_o (), .side_o ()
  );

  psaf_pkg::motion_t out_mot;
  assign out_mot = psaf_pkg::motion_t'(cu_side[UV_SW-1 -: MOT_W]);

  assign out_valid     = cu_valid;
  assign out_new_pos_x = out_mot.pos_x;
  assign out_new_pos_y = out_mot.pos_y;
  assign out_new_pos_z = out_mot.pos_z;
  assign out_new_vel_y = out_mot.vel_y;
  assign out_new_age   = out_mot.new_age;
  assign out_alive     = out_mot.alive;
  assign out_blend     = cu_side[UV_W-1:0];
  assign out_cur_u     = cu_q;
  assign out_cur_v     = cv_q;
  assign out_next_u    = nu_q;
  assign out_next_v    = nv_q;

  `PSAF_ASSERT_IMP(a_busy_quiet, clk, rst_n, busy_r, (!out_valid))
  `PSAF_ASSERT_IMP(a_fixed_latency, clk, rst_n, in_accept, ##LATENCY out_valid)
  `PSAF_ASSERT_IMP(a_cur_in_range, clk, rst_n, md_valid, (md_cur <= last_idx))
  `PSAF_ASSERT_NXT(a_last_holds, clk, rst_n, (cd_valid && cd_last), (ncol_r == col_r && nrow_r == row_r))
  `PSAF_ASSERT_IMP(a_next_ahead, clk, rst_n, nx_valid_r, (nrow_r > row_r || (nrow_r == row_r && ncol_r >= col_r)))

endmodule
